[rtl/core/address_range_region_lookup_unit_macros.svh]
// assertion macros for the address range region lookup unit
// used by the checker module; no other dependencies
`ifndef ADDRESS_RANGE_REGION_LOOKUP_UNIT_MACROS_SVH
`define ADDRESS_RANGE_REGION_LOOKUP_UNIT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ARR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");

// expression must never be true outside reset
`define ARR_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  `ARR_ASSERT(lbl, clk, rst_n, !(expr))

`endif

[rtl/core/arr_pkg.sv]
// shared types and constants for the address range region lookup unit
// no dependencies
package arr_pkg;

  localparam int MaxRegionsDef = 64;
  localparam int CountW        = 7;
  localparam int SlotW         = 6;
  localparam int AddrW         = 64;
  localparam int LenW          = 32;

  localparam logic ActWrite  = 1'b0;
  localparam logic ActLookup = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [LenW-1:0]  length;
    logic [AddrW-1:0] base;
  } entry_t;

  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
  } tbl_ctrl_t;

  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] index;
    logic [AddrW-1:0] base;
    logic [LenW-1:0]  length;
  } res_t;

endpackage

[rtl/core/address_range_region_lookup_unit.sv]
// address range region lookup unit, top level
// depends on arr_pkg, arr_scan and arr_table
//
// Input stream s_axis carries one item per transfer: tuser is the action
// (0 writes a table slot, 1 looks up an address). A write stores base and
// length at the slot and returns a miss result as acknowledgement. A lookup
// walks entries 0 .. region_count-1 and returns the first region holding
// the address, or a miss. Every item yields exactly one result on m_axis.
// region_count is loaded over the cfg channel, which is always ready; write
// it only while no item is in flight.
// A write, a zero address or a zero count goes straight to the result state;
// a lookup scans at most region_count entries (count capped at the table
// size), one table entry per cycle, set by the single read port of the
// table memory. Items are handled one at a time.
// The output register holds a finished result while the next item is
// taken in; if m_axis stalls, a second result waits and s_axis stops.
// Reset clears the control state and region_count; table contents are
// undefined until written, and no clearing pass runs.
module address_range_region_lookup_unit #(
  parameter int MaxRegions = arr_pkg::MaxRegionsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_slot[5:0], entry_base[69:6], entry_length[101:70],
  // query_address[165:102], zero pad[167:166]
  input  logic [167:0] s_axis_tdata,
  // action[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // region_index[5:0], region_base[69:6], region_length[101:70], zero pad[103:102]
  output logic [103:0] m_axis_tdata,
  // hit[0]
  output logic         m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  // region_count[6:0]
  input  logic [arr_pkg::CountW-1:0] cfg_data_i
);
  import arr_pkg::*;

  localparam int IdxW = (MaxRegions > 1) ? $clog2(MaxRegions) : 1;

  logic [CountW-1:0] region_count_q;
  tbl_ctrl_t         tbl_ctrl;
  logic [IdxW-1:0]   wr_addr;
  logic [IdxW-1:0]   rd_addr;
  entry_t            wr_entry;
  entry_t            rd_entry;
  res_t              res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      region_count_q <= cfg_data_i;
    end
  end

  arr_scan #(.MaxRegions(MaxRegions)) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (s_axis_tuser),
    .in_slot_i   (s_axis_tdata[5:0]),
    .in_base_i   (s_axis_tdata[69:6]),
    .in_length_i (s_axis_tdata[101:70]),
    .in_addr_i   (s_axis_tdata[165:102]),
    .count_i     (region_count_q),
    .tbl_ctrl_o  (tbl_ctrl),
    .wr_addr_o   (wr_addr),
    .wr_entry_o  (wr_entry),
    .rd_addr_o   (rd_addr),
    .rd_entry_i  (rd_entry),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  arr_table #(.MaxRegions(MaxRegions)) u_table (
    .clk_i      (clk_i),
    .ctrl_i     (tbl_ctrl),
    .wr_addr_i  (wr_addr),
    .wr_entry_i (wr_entry),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry)
  );

  assign m_axis_tuser = res.hit;
  assign m_axis_tdata = {2'b00, res.length, res.base, res.index};

endmodule

[rtl/core/arr_table.sv]
// region table memory: one write port, one read port with registered data
// depends on arr_pkg
module arr_table #(
  parameter int MaxRegions = arr_pkg::MaxRegionsDef,
  localparam int IdxW = (MaxRegions > 1) ? $clog2(MaxRegions) : 1
) (
  input  logic               clk_i,
  input  arr_pkg::tbl_ctrl_t ctrl_i,
  input  logic [IdxW-1:0]    wr_addr_i,
  input  arr_pkg::entry_t    wr_entry_i,
  input  logic [IdxW-1:0]    rd_addr_i,
  output arr_pkg::entry_t    rd_entry_o
);
  import arr_pkg::*;

  entry_t mem [MaxRegions];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_addr_i] <= wr_entry_i;
    end
    if (ctrl_i.rd_en) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_entry_o = rd_q;

endmodule

[rtl/core/arr_scan.sv]
// item sequencer: table writes, pipelined lookup scan and result register
// depends on arr_pkg, drives arr_table
module arr_scan #(
  parameter int MaxRegions = arr_pkg::MaxRegionsDef,
  localparam int IdxW = (MaxRegions > 1) ? $clog2(MaxRegions) : 1,
  localparam int CntW = $clog2(MaxRegions + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        in_action_i,
  input  logic [arr_pkg::SlotW-1:0]   in_slot_i,
  input  logic [arr_pkg::AddrW-1:0]   in_base_i,
  input  logic [arr_pkg::LenW-1:0]    in_length_i,
  input  logic [arr_pkg::AddrW-1:0]   in_addr_i,
  input  logic [arr_pkg::CountW-1:0]  count_i,
  output arr_pkg::tbl_ctrl_t          tbl_ctrl_o,
  output logic [IdxW-1:0]             wr_addr_o,
  output arr_pkg::entry_t             wr_entry_o,
  output logic [IdxW-1:0]             rd_addr_o,
  input  arr_pkg::entry_t             rd_entry_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output arr_pkg::res_t               out_res_o
);
  import arr_pkg::*;

  state_e            state_q, state_d;
  logic [CntW-1:0]   rd_idx_q;
  logic [CntW-1:0]   limit_q;
  logic [CntW-1:0]   limit_in;
  logic [CntW-1:0]   cmp_idx_q;
  logic              cmp_vld_q;
  logic [AddrW-1:0]  addr_q;
  logic [AddrW-1:0]  region_end;
  res_t              res_q;
  res_t              out_q;
  logic              out_valid_q;
  logic              in_accept;
  logic              issue;
  logic              hit_now;
  logic              last_now;
  logic              res_move;

  assign in_accept = in_valid_i && in_ready_o;

  // count above table size saturates
  assign limit_in = (int'(count_i) > MaxRegions) ? CntW'(MaxRegions) : CntW'(count_i);

  assign issue      = (state_q == ST_SCAN) && (rd_idx_q < limit_q);
  assign region_end = rd_entry_i.base + AddrW'(rd_entry_i.length);
  // a wrapped end is below base, so it can never match
  assign hit_now    = cmp_vld_q && (addr_q >= rd_entry_i.base) && (addr_q < region_end);
  assign last_now   = cmp_vld_q && (cmp_idx_q == limit_q - CntW'(1));
  assign res_move   = (state_q == ST_RESULT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_action_i == ActWrite) begin
            state_d = ST_RESULT;
          end else if ((in_addr_i == '0) || (limit_in == '0)) begin
            state_d = ST_RESULT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit_now || last_now) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (res_move) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = (state_q == ST_IDLE);
    tbl_ctrl_o.wr_en = in_accept && (in_action_i == ActWrite) && (int'(in_slot_i) < MaxRegions);
    tbl_ctrl_o.rd_en = issue;
  end

  assign wr_addr_o         = IdxW'(in_slot_i);
  assign wr_entry_o.base   = in_base_i;
  assign wr_entry_o.length = in_length_i;
  assign rd_addr_o         = rd_idx_q[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmp_vld_q   <= 1'b0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= issue;
      if (in_accept) begin
        rd_idx_q <= '0;
      end else if (issue) begin
        rd_idx_q <= rd_idx_q + CntW'(1);
      end
      if (res_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= rd_idx_q;
    if (in_accept) begin
      addr_q  <= in_addr_i;
      limit_q <= limit_in;
      res_q   <= '0;
    end else if ((state_q == ST_SCAN) && hit_now) begin
      res_q.hit    <= 1'b1;
      res_q.index  <= SlotW'(cmp_idx_q);
      res_q.base   <= rd_entry_i.base;
      res_q.length <= rd_entry_i.length;
    end
    if (res_move) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

[rtl/core/arr_checker.sv]
// port-level checks for the address range region lookup unit, with bind
// depends on address_range_region_lookup_unit_macros.svh
`include "address_range_region_lookup_unit_macros.svh"

module arr_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         cfg_ready_o
);

  logic [1:0] pending_q;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // items taken in whose result transfer has not happened yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 2'(in_xfer) - 2'(out_xfer);
    end
  end

  `ARR_ASSERT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  `ARR_ASSERT_NEVER(a_result_without_item, clk_i, rst_ni,
    m_axis_tvalid && (pending_q == 2'd0))
  `ARR_ASSERT_NEVER(a_too_many_in_flight, clk_i, rst_ni,
    (pending_q == 2'd2) && s_axis_tready || (pending_q == 2'd3))
  `ARR_ASSERT(a_miss_is_zero, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == '0))
  `ARR_ASSERT(a_cfg_ready, clk_i, rst_ni, cfg_ready_o)

endmodule

bind address_range_region_lookup_unit arr_checker u_arr_checker (.*);
